[sv/tlvp_pkg.sv]
// Shared types, codes and helpers of the command argument TLV parser.
package tlvp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CODE_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_U8  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_U16 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_U32 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_F32 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_STR = 3'd4;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_NUM    = 3'd1;
  localparam logic [2:0] KIND_SSTART = 3'd2;
  localparam logic [2:0] KIND_SBYTE  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [2:0] ARG_U8  = 3'd0;
  localparam logic [2:0] ARG_U16 = 3'd1;
  localparam logic [2:0] ARG_U32 = 3'd2;
  localparam logic [2:0] ARG_F32 = 3'd3;
  localparam logic [2:0] ARG_STR = 3'd4;

  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  localparam logic [7:0] U8_BYTES  = 8'd1;
  localparam logic [7:0] U16_BYTES = 8'd2;
  localparam logic [7:0] U32_BYTES = 8'd4;

  typedef enum logic [7:0] {
    PH_H0     = 8'b0000_0001,
    PH_H1     = 8'b0000_0010,
    PH_COUNT  = 8'b0000_0100,
    PH_TYPE   = 8'b0000_1000,
    PH_NUM    = 8'b0001_0000,
    PH_SLEN   = 8'b0010_0000,
    PH_SBYTES = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [CODE_W-1:0] u8;
    logic [CODE_W-1:0] u16;
    logic [CODE_W-1:0] u32;
    logic [CODE_W-1:0] f32;
    logic [CODE_W-1:0] str;
  } codes_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  arg_count;
    logic [7:0]  arg_index;
    logic [2:0]  arg_type;
    logic [31:0] value;
    logic [1:0]  end_status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  function automatic result_t mk_res(logic [2:0] kind, logic [7:0] f, logic [7:0] s,
                                     logic [7:0] c, logic [7:0] idx, logic [2:0] atype,
                                     logic [31:0] val, logic [1:0] status, logic lst);
    result_t r;
    r.kind        = kind;
    r.first_byte  = f;
    r.second_byte = s;
    r.arg_count   = c;
    r.arg_index   = idx;
    r.arg_type    = atype;
    r.value       = val;
    r.end_status  = status;
    r.last        = lst;
    return r;
  endfunction

endpackage

[sv/tlvp_if.sv]
// Valid/ready channel interfaces for payload words and result words.
interface tlvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic [7:0]  arg_count;
  logic [7:0]  arg_index;
  logic [2:0]  arg_type;
  logic [31:0] value;
  logic [1:0]  end_status;
  logic        last;

  modport source (output valid, output kind, output first_byte, output second_byte,
                  output arg_count, output arg_index, output arg_type, output value,
                  output end_status, output last, input ready);
  modport sink (input valid, input kind, input first_byte, input second_byte,
                input arg_count, input arg_index, input arg_type, input value,
                input end_status, input last, output ready);
endinterface

[sv/tlvp_core.sv]
// Parser state and the combinational decode of one payload word into up to two results.
module tlvp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  tlvp_pkg::codes_t codes,
  output tlvp_pkg::push_t  push,
  output tlvp_pkg::result_t res0,
  output tlvp_pkg::result_t res1
);
  import tlvp_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  header_first, header_first_next;
  logic [7:0]  header_second, header_second_next;
  logic [7:0]  count_declared, count_declared_next;
  logic [7:0]  args_seen, args_seen_next;
  logic [2:0]  current_type, current_type_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [31:0] value_accum, value_accum_next;
  logic [1:0]  byte_slot, byte_slot_next;

  logic        ended, idle, arg_v, end_v;
  logic [1:0]  status;
  result_t     arg_res, end_res;

  always_comb begin
    phase_next          = phase;
    header_first_next   = header_first;
    header_second_next  = header_second;
    count_declared_next = count_declared;
    args_seen_next      = args_seen;
    current_type_next   = current_type;
    bytes_left_next     = bytes_left;
    value_accum_next    = value_accum;
    byte_slot_next      = byte_slot;
    ended   = 1'b0;
    idle    = 1'b0;
    arg_v   = 1'b0;
    end_v   = 1'b0;
    status  = ST_COMPLETE;
    arg_res = mk_res(KIND_HEADER, 8'd0, 8'd0, 8'd0, 8'd0, ARG_U8, 32'd0, ST_COMPLETE, 1'b0);

    case (phase)
      PH_H0: begin
        header_first_next   = data_byte;
        header_second_next  = 8'd0;
        count_declared_next = 8'd0;
        args_seen_next      = 8'd0;
        current_type_next   = ARG_U8;
        bytes_left_next     = 8'd0;
        value_accum_next    = 32'd0;
        byte_slot_next      = 2'd0;
        phase_next          = PH_H1;
        if (last_byte) begin
          ended  = 1'b1;
          status = ST_SHORT;
        end
      end
      PH_H1: begin
        header_second_next = data_byte;
        phase_next         = PH_COUNT;
        if (last_byte) begin
          ended  = 1'b1;
          status = ST_SHORT;
        end
      end
      PH_COUNT: begin
        count_declared_next = data_byte;
        args_seen_next      = 8'd0;
        arg_v   = 1'b1;
        arg_res = mk_res(KIND_HEADER, header_first, header_second, data_byte, 8'd0,
                         ARG_U8, 32'd0, ST_COMPLETE, 1'b0);
        phase_next = PH_TYPE;
        if (data_byte == 8'd0) begin
          ended = 1'b1;
        end
      end
      PH_TYPE: begin
        value_accum_next = 32'd0;
        byte_slot_next   = 2'd0;
        if (data_byte == codes.u8) begin
          current_type_next = ARG_U8;
          bytes_left_next   = U8_BYTES;
          phase_next        = PH_NUM;
        end else if (data_byte == codes.u16) begin
          current_type_next = ARG_U16;
          bytes_left_next   = U16_BYTES;
          phase_next        = PH_NUM;
        end else if (data_byte == codes.u32) begin
          current_type_next = ARG_U32;
          bytes_left_next   = U32_BYTES;
          phase_next        = PH_NUM;
        end else if (data_byte == codes.f32) begin
          current_type_next = ARG_F32;
          bytes_left_next   = U32_BYTES;
          phase_next        = PH_NUM;
        end else if (data_byte == codes.str) begin
          current_type_next = ARG_STR;
          phase_next        = PH_SLEN;
        end else begin
          ended  = 1'b1;
          status = ST_UNKNOWN;
        end
      end
      PH_NUM: begin
        value_accum_next = value_accum | (32'(data_byte) << {byte_slot, 3'b000});
        byte_slot_next   = byte_slot + 2'd1;
        bytes_left_next  = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          arg_v   = 1'b1;
          arg_res = mk_res(KIND_NUM, header_first, header_second, count_declared,
                           args_seen, current_type, value_accum_next, ST_COMPLETE, 1'b0);
          phase_next     = PH_TYPE;
          args_seen_next = args_seen + 8'd1;
          ended          = (args_seen_next == count_declared);
        end
      end
      PH_SLEN: begin
        bytes_left_next = data_byte;
        arg_v   = 1'b1;
        arg_res = mk_res(KIND_SSTART, header_first, header_second, count_declared,
                         args_seen, ARG_STR, 32'(data_byte), ST_COMPLETE, 1'b0);
        phase_next = PH_SBYTES;
        if (data_byte == 8'd0) begin
          phase_next     = PH_TYPE;
          args_seen_next = args_seen + 8'd1;
          ended          = (args_seen_next == count_declared);
        end
      end
      PH_SBYTES: begin
        arg_v   = 1'b1;
        arg_res = mk_res(KIND_SBYTE, header_first, header_second, count_declared,
                         args_seen, ARG_STR, 32'(data_byte), ST_COMPLETE, 1'b0);
        bytes_left_next = bytes_left - 8'd1;
        if (bytes_left_next == 8'd0) begin
          phase_next     = PH_TYPE;
          args_seen_next = args_seen + 8'd1;
          ended          = (args_seen_next == count_declared);
        end
      end
      default: begin
        idle = 1'b1;
        if (last_byte) begin
          phase_next = PH_H0;
        end
      end
    endcase

    if (!idle) begin
      if (ended) begin
        end_v      = 1'b1;
        phase_next = last_byte ? PH_H0 : PH_DONE;
      end else if (last_byte) begin
        end_v      = 1'b1;
        status     = ST_TRUNC;
        phase_next = PH_H0;
      end
    end

    end_res = mk_res(KIND_END, header_first_next, header_second_next, count_declared_next,
                     args_seen_next, ARG_U8, 32'd0, status, 1'b1);
    push.v0 = accept & (arg_v | end_v);
    push.v1 = accept & arg_v & end_v;
    res0    = arg_v ? arg_res : end_res;
    res1    = end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_H0;
      header_first   <= 8'd0;
      header_second  <= 8'd0;
      count_declared <= 8'd0;
      args_seen      <= 8'd0;
      current_type   <= ARG_U8;
      bytes_left     <= 8'd0;
      value_accum    <= 32'd0;
      byte_slot      <= 2'd0;
    end else if (accept) begin
      phase          <= phase_next;
      header_first   <= header_first_next;
      header_second  <= header_second_next;
      count_declared <= count_declared_next;
      args_seen      <= args_seen_next;
      current_type   <= current_type_next;
      bytes_left     <= bytes_left_next;
      value_accum    <= value_accum_next;
      byte_slot      <= byte_slot_next;
    end
  end

endmodule

[sv/tlvp_fifo.sv]
// Result queue that takes up to two results a cycle and hands out one.
module tlvp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tlvp_pkg::push_t           push,
  input  tlvp_pkg::result_t         d0,
  input  tlvp_pkg::result_t         d1,
  input  logic                      pop,
  output tlvp_pkg::result_t         head,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import tlvp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH+1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wp, rp, wp1;
  logic [LVL_W-1:0]   level_next;

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1  = inc(wp);
  assign head = mem[rp];
  assign level_next = level + LVL_W'(push.v0) + LVL_W'(push.v1) - LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp] <= d0;
    end
    if (push.v1) begin
      mem[wp1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push.v1) begin
        wp <= inc(wp1);
      end else if (push.v0) begin
        wp <= wp1;
      end
      if (pop) begin
        rp <= inc(rp);
      end
      level <= level_next;
    end
  end

endmodule

[sv/command_argument_tlv_parser_top.sv]
// Top level of the command argument TLV parser: type code registers, parser and result queue.
//
// The payload channel takes one command payload word (one byte) per handshake, with
// last_byte set on the final byte. The results channel gives header, numeric argument,
// string start, string byte and end status words; every payload ends in one end status
// word with last set. Type codes are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the block is idle, which the block does not enforce. Indexes
// beyond the five type registers are ignored. A byte is decoded in the cycle it is accepted
// and its results are written into a queue of DEPTH entries; with the queue empty, the first
// result is valid on the results channel in the cycle after the byte is accepted. The block
// takes one byte per cycle while payload ready is high; a byte gives at most two results, and
// payload ready stays high while the queue has room for two more results. When the receiver
// stalls the queue fills and payload ready falls; nothing is lost. Reset (rst, synchronous)
// empties the queue, sets the parser to expect header byte zero, type codes to 0 through 4.
module command_argument_tlv_parser_top #(
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  tlvp_in_if.sink                        payload,
  tlvp_out_if.source                     results,
  input  logic                           cfg_we,
  input  logic [tlvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlvp_pkg::CODE_W-1:0]    cfg_data
);
  import tlvp_pkg::*;

  localparam int LVL_W = $clog2(DEPTH+1);

  codes_t            codes;
  push_t             push;
  result_t           res0, res1, head;
  logic [LVL_W-1:0]  level;
  logic              accept, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.u8  <= 8'd0;
      codes.u16 <= 8'd1;
      codes.u32 <= 8'd2;
      codes.f32 <= 8'd3;
      codes.str <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CODE_U8:  codes.u8  <= cfg_data;
        CFG_CODE_U16: codes.u16 <= cfg_data;
        CFG_CODE_U32: codes.u32 <= cfg_data;
        CFG_CODE_F32: codes.f32 <= cfg_data;
        CFG_CODE_STR: codes.str <= cfg_data;
        default: ;
      endcase
    end
  end

  assign payload.ready = !rst && (level <= LVL_W'(DEPTH-2));
  assign accept        = payload.valid & payload.ready;
  assign pop           = results.valid & results.ready;

  tlvp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (payload.data_byte),
    .last_byte (payload.last_byte),
    .codes     (codes),
    .push      (push),
    .res0      (res0),
    .res1      (res1)
  );

  tlvp_fifo #(.DEPTH(DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .d0    (res0),
    .d1    (res1),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  assign results.valid       = (level != '0);
  assign results.kind        = head.kind;
  assign results.first_byte  = head.first_byte;
  assign results.second_byte = head.second_byte;
  assign results.arg_count   = head.arg_count;
  assign results.arg_index   = head.arg_index;
  assign results.arg_type    = head.arg_type;
  assign results.value       = head.value;
  assign results.end_status  = head.end_status;
  assign results.last        = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(DEPTH))
    else $error("result queue holds more words than it has entries");

  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.v0 && res1.kind == KIND_END && res1.last))
    else $error("second result of a byte is not an end status");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.last) |-> results.kind == KIND_END)
    else $error("last flag on a word that is not an end status");

  a_no_push_without_accept: assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> accept)
    else $error("result written without an accepted byte");

endmodule
